// ===== sv/v5cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// v5cpd_pkg : shared definitions for the client packet descrambler
// Constants, sequencer state type, checkcode bit permutation and the
// 256-entry scramble table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package v5cpd_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 2048;
   localparam int HDR_BYTES            = 24;
   localparam int HDR_IDX_W            = 5;
   localparam int SCRAMBLE_START       = 'h0a;
   localparam int CHECK_OFS            = 'h14;
   localparam int CHECK_BYTES          = 4;
   localparam int SHORT_LIMIT          = 20;
   localparam logic [31:0] LEN_MULT    = 32'h6865_6C6C;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_KEY,
      ST_BURST,
      ST_STREAM
   } state_type;

   function automatic logic [31:0] permute_check(input logic [31:0] code);
      logic [31:0] sum;
      sum = ((code & 32'h0001_f000) >> 12)
          + ((code & 32'h07c0_07c0) >> 1)
          + ((code & 32'h003e_0001) << 10)
          + ((code & 32'hf800_0000) >> 16)
          + ((code & 32'h0000_083e) << 15);
      return sum;
   endfunction

   localparam logic [7:0] ROM_V5 [256] = '{
      8'h59, 8'h60, 8'h37, 8'h6B, 8'h65, 8'h62, 8'h46, 8'h48,
      8'h53, 8'h61, 8'h4C, 8'h59, 8'h60, 8'h57, 8'h5B, 8'h3D,
      8'h5E, 8'h34, 8'h6D, 8'h36, 8'h50, 8'h3F, 8'h6F, 8'h67,
      8'h53, 8'h61, 8'h4C, 8'h59, 8'h40, 8'h47, 8'h63, 8'h39,
      8'h50, 8'h5F, 8'h5F, 8'h3F, 8'h6F, 8'h47, 8'h43, 8'h69,
      8'h48, 8'h33, 8'h31, 8'h64, 8'h35, 8'h5A, 8'h4A, 8'h42,
      8'h56, 8'h40, 8'h67, 8'h53, 8'h41, 8'h07, 8'h6C, 8'h49,
      8'h58, 8'h3B, 8'h4D, 8'h46, 8'h68, 8'h43, 8'h69, 8'h48,
      8'h33, 8'h31, 8'h44, 8'h65, 8'h62, 8'h46, 8'h48, 8'h53,
      8'h41, 8'h07, 8'h6C, 8'h69, 8'h48, 8'h33, 8'h51, 8'h54,
      8'h5D, 8'h4E, 8'h6C, 8'h49, 8'h38, 8'h4B, 8'h55, 8'h4A,
      8'h62, 8'h46, 8'h48, 8'h33, 8'h51, 8'h34, 8'h6D, 8'h36,
      8'h50, 8'h5F, 8'h5F, 8'h5F, 8'h3F, 8'h6F, 8'h47, 8'h63,
      8'h59, 8'h40, 8'h67, 8'h33, 8'h31, 8'h64, 8'h35, 8'h5A,
      8'h6A, 8'h52, 8'h6E, 8'h3C, 8'h51, 8'h34, 8'h6D, 8'h36,
      8'h50, 8'h5F, 8'h5F, 8'h3F, 8'h4F, 8'h37, 8'h4B, 8'h35,
      8'h5A, 8'h4A, 8'h62, 8'h66, 8'h58, 8'h3B, 8'h4D, 8'h66,
      8'h58, 8'h5B, 8'h5D, 8'h4E, 8'h6C, 8'h49, 8'h58, 8'h3B,
      8'h4D, 8'h66, 8'h58, 8'h3B, 8'h4D, 8'h46, 8'h48, 8'h53,
      8'h61, 8'h4C, 8'h59, 8'h40, 8'h67, 8'h33, 8'h31, 8'h64,
      8'h55, 8'h6A, 8'h32, 8'h3E, 8'h44, 8'h45, 8'h52, 8'h6E,
      8'h3C, 8'h31, 8'h64, 8'h55, 8'h6A, 8'h52, 8'h4E, 8'h6C,
      8'h69, 8'h48, 8'h53, 8'h61, 8'h4C, 8'h39, 8'h30, 8'h6F,
      8'h47, 8'h63, 8'h59, 8'h60, 8'h57, 8'h5B, 8'h3D, 8'h3E,
      8'h64, 8'h35, 8'h3A, 8'h3A, 8'h5A, 8'h6A, 8'h52, 8'h4E,
      8'h6C, 8'h69, 8'h48, 8'h53, 8'h61, 8'h6C, 8'h49, 8'h58,
      8'h3B, 8'h4D, 8'h46, 8'h68, 8'h63, 8'h39, 8'h50, 8'h5F,
      8'h5F, 8'h3F, 8'h6F, 8'h67, 8'h53, 8'h41, 8'h25, 8'h41,
      8'h3C, 8'h51, 8'h54, 8'h3D, 8'h5E, 8'h54, 8'h5D, 8'h4E,
      8'h4C, 8'h39, 8'h50, 8'h5F, 8'h5F, 8'h5F, 8'h3F, 8'h6F,
      8'h47, 8'h43, 8'h69, 8'h48, 8'h33, 8'h51, 8'h54, 8'h5D,
      8'h6E, 8'h3C, 8'h31, 8'h64, 8'h35, 8'h5A, 8'h00, 8'h00
   };

endpackage

// ===== sv/v5cpd_lane_xor.sv =====
// ----------------------------------------------------------------------------
// v5cpd_lane_xor : per-byte descramble unit
// Selects the byte lane of key plus table value for the four-byte group
// holding the position and XORs it into the byte; positions outside the
// scrambled area pass unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v5cpd_lane_xor #(
   parameter int MAX_PACKET_BYTES = v5cpd_pkg::MAX_PACKET_BYTES_DEF,
   parameter int POS_W            = ($clog2(MAX_PACKET_BYTES + 1) > 8)
                                  ? $clog2(MAX_PACKET_BYTES + 1) : 8
) (
   input  logic             decrypt_enable,
   input  logic [POS_W-1:0] position,
   input  logic [7:0]       data_byte,
   input  logic [31:0]      key,
   output logic [7:0]       plain_byte
);

   logic        in_range;
   logic        is_check;
   logic [1:0]  lane;
   logic [7:0]  grp;
   logic [31:0] lane_key;
   logic [7:0]  key_byte;

   always_comb begin
      is_check = (position >= POS_W'(v5cpd_pkg::CHECK_OFS))
              && (position < POS_W'(v5cpd_pkg::CHECK_OFS + v5cpd_pkg::CHECK_BYTES));
      in_range = decrypt_enable
              && (position >= POS_W'(v5cpd_pkg::SCRAMBLE_START))
              && (position < POS_W'(MAX_PACKET_BYTES))
              && !is_check;
      lane     = position[1:0] - 2'(v5cpd_pkg::SCRAMBLE_START);
      grp      = position[7:0] - {6'd0, lane};
      lane_key = key + {24'd0, v5cpd_pkg::ROM_V5[grp]};
      case (lane)
         2'd0:    key_byte = lane_key[7:0];
         2'd1:    key_byte = lane_key[15:8];
         2'd2:    key_byte = lane_key[23:16];
         default: key_byte = lane_key[31:24];
      endcase
      plain_byte = in_range ? (data_byte ^ key_byte) : data_byte;
   end

endmodule

// ===== sv/v5_client_packet_descrambler.sv =====
// ----------------------------------------------------------------------------
// v5_client_packet_descrambler : client packet descrambler
// Collects the first 24 bytes of a packet, one per cycle, with no output.
// On the 24th byte (or an earlier final byte) the key state forms the key
// from the checkcode and the packet length, then the held bytes leave one
// per cycle while the output is not stalled, with requests stalled.
// Later bytes stream through at one per cycle while the output is not
// stalled, set by the single result register. Packets whose length field
// on the releasing byte is 20 or less pass unchanged with a zero key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v5_client_packet_descrambler #(
   parameter int MAX_PACKET_BYTES = v5cpd_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [11:0] req_packet_length,
   input  logic        req_end_of_packet,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_plain_byte,
   output logic        rsp_final_byte,
   output logic [31:0] rsp_packet_key
);

   localparam int POS_W = ($clog2(MAX_PACKET_BYTES + 1) > 8)
                        ? $clog2(MAX_PACKET_BYTES + 1) : 8;
   localparam int IDX_W = v5cpd_pkg::HDR_IDX_W;

   v5cpd_pkg::state_type state_ff, state_in;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hdr_ff [v5cpd_pkg::HDR_BYTES];
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] end_idx_ff, end_idx_in;
   logic             last_ff, last_in;
   logic             enable_ff, enable_in;
   logic [31:0]      prod_ff, prod_in;
   logic [31:0]      key_ff, key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_plain_byte_ff, rsp_plain_byte_in;
   logic             rsp_final_byte_ff, rsp_final_byte_in;
   logic [31:0]      rsp_packet_key_ff, rsp_packet_key_in;

   logic             out_free;
   logic             req_accept;
   logic             hdr_we;
   logic             load;
   logic             release_hdr;
   logic             burst_done;
   logic [31:0]      code;
   logic [POS_W-1:0] lane_pos;
   logic [7:0]       lane_byte;
   logic [7:0]       lane_plain;

   // handshake and sequencing control
   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      req_stall   = 1'b1;
      unique case (state_ff)
         v5cpd_pkg::ST_COLLECT: req_stall = 1'b0;
         v5cpd_pkg::ST_KEY:     req_stall = 1'b1;
         v5cpd_pkg::ST_BURST:   req_stall = 1'b1;
         v5cpd_pkg::ST_STREAM:  req_stall = !out_free;
         default:               req_stall = 1'b1;
      endcase
      req_accept  = req_valid && !req_stall;
      hdr_we      = req_accept && (state_ff == v5cpd_pkg::ST_COLLECT);
      release_hdr = req_end_of_packet
                 || (pos_ff == POS_W'(v5cpd_pkg::HDR_BYTES - 1));
      burst_done  = (idx_ff == end_idx_ff);
      load        = ((state_ff == v5cpd_pkg::ST_BURST) && out_free)
                 || ((state_ff == v5cpd_pkg::ST_STREAM) && req_accept);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         v5cpd_pkg::ST_COLLECT:
            if (req_accept && release_hdr) state_in = v5cpd_pkg::ST_KEY;
         v5cpd_pkg::ST_KEY:
            state_in = v5cpd_pkg::ST_BURST;
         v5cpd_pkg::ST_BURST:
            if (out_free && burst_done) begin
               state_in = last_ff ? v5cpd_pkg::ST_COLLECT : v5cpd_pkg::ST_STREAM;
            end
         v5cpd_pkg::ST_STREAM:
            if (req_accept && req_end_of_packet) state_in = v5cpd_pkg::ST_COLLECT;
         default:
            state_in = v5cpd_pkg::ST_COLLECT;
      endcase
   end

   // checkcode, with bytes not received reading as zero
   always_comb begin
      code = '0;
      for (int j = 0; j < v5cpd_pkg::CHECK_BYTES; j++) begin
         if (IDX_W'(v5cpd_pkg::CHECK_OFS + j) <= end_idx_ff) begin
            code[8*j +: 8] = hdr_ff[v5cpd_pkg::CHECK_OFS + j];
         end
      end
   end

   assign lane_pos  = (state_ff == v5cpd_pkg::ST_BURST) ? POS_W'(idx_ff) : pos_ff;
   assign lane_byte = (state_ff == v5cpd_pkg::ST_BURST) ? hdr_ff[idx_ff] : req_data_byte;

   v5cpd_lane_xor #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .POS_W            (POS_W)
   ) u_lane_xor (
      .decrypt_enable (enable_ff),
      .position       (lane_pos),
      .data_byte      (lane_byte),
      .key            (key_ff),
      .plain_byte     (lane_plain)
   );

   // datapath next values
   always_comb begin
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      end_idx_in = end_idx_ff;
      last_in    = last_ff;
      enable_in  = enable_ff;
      prod_in    = prod_ff;
      key_in     = key_ff;
      unique case (state_ff)
         v5cpd_pkg::ST_COLLECT:
            if (req_accept) begin
               if (release_hdr) begin
                  end_idx_in = pos_ff[IDX_W-1:0];
                  last_in    = req_end_of_packet;
                  enable_in  = req_packet_length > 12'(v5cpd_pkg::SHORT_LIMIT);
                  prod_in    = 32'(32'(req_packet_length) * v5cpd_pkg::LEN_MULT);
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         v5cpd_pkg::ST_KEY: begin
            idx_in = '0;
            key_in = enable_ff ? (prod_ff + v5cpd_pkg::permute_check(code)) : '0;
         end
         v5cpd_pkg::ST_BURST:
            if (out_free) begin
               idx_in = idx_ff + IDX_W'(1);
               if (burst_done) begin
                  if (last_ff) begin
                     pos_in    = '0;
                     key_in    = '0;
                     enable_in = 1'b0;
                  end else begin
                     pos_in = POS_W'(v5cpd_pkg::HDR_BYTES);
                  end
               end
            end
         v5cpd_pkg::ST_STREAM:
            if (req_accept) begin
               if (req_end_of_packet) begin
                  pos_in    = '0;
                  key_in    = '0;
                  enable_in = 1'b0;
               end else if (pos_ff < POS_W'(MAX_PACKET_BYTES)) begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         default: begin
            pos_in = '0;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !out_free;
      rsp_plain_byte_in = rsp_plain_byte_ff;
      rsp_final_byte_in = rsp_final_byte_ff;
      rsp_packet_key_in = rsp_packet_key_ff;
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_plain_byte_in = lane_plain;
         rsp_packet_key_in = key_ff;
         rsp_final_byte_in = (state_ff == v5cpd_pkg::ST_BURST) ? (last_ff && burst_done)
                                                               : req_end_of_packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= v5cpd_pkg::ST_COLLECT;
         pos_ff       <= '0;
         idx_ff       <= '0;
         end_idx_ff   <= '0;
         last_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         end_idx_ff   <= end_idx_in;
         last_ff      <= last_in;
         enable_ff    <= enable_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff           <= prod_in;
      rsp_plain_byte_ff <= rsp_plain_byte_in;
      rsp_final_byte_ff <= rsp_final_byte_in;
      rsp_packet_key_ff <= rsp_packet_key_in;
      if (hdr_we) begin
         hdr_ff[pos_ff[IDX_W-1:0]] <= req_data_byte;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_plain_byte_ff;
   assign rsp_final_byte = rsp_final_byte_ff;
   assign rsp_packet_key = rsp_packet_key_ff;

   a_collect_in_header : assert property (@(posedge clock) disable iff (reset)
      state_ff == v5cpd_pkg::ST_COLLECT |-> pos_ff < POS_W'(v5cpd_pkg::HDR_BYTES))
      else $error("collect position beyond header");

   a_key_to_burst : assert property (@(posedge clock) disable iff (reset)
      state_ff == v5cpd_pkg::ST_KEY |=> state_ff == v5cpd_pkg::ST_BURST && idx_ff == '0)
      else $error("key cycle not followed by burst from first byte");

   a_hold_during_burst : assert property (@(posedge clock) disable iff (reset)
      (state_ff == v5cpd_pkg::ST_KEY || state_ff == v5cpd_pkg::ST_BURST) |-> req_stall)
      else $error("request taken while header is released");

   a_key_zero_when_off : assert property (@(posedge clock) disable iff (reset)
      !enable_ff |-> key_ff == '0)
      else $error("non-zero key with decryption off");

endmodule
